@@ hw/rtl/sgbq_pkg.sv @@
package sgbq_pkg;

	localparam int LAT_W     = 18;
	localparam int LON_W     = 20;
	localparam int ALT_W     = 17;
	localparam int STEP_W    = 16;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int NUM_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 7;
	localparam int LAYER_W   = 4;

	localparam int LATP_W = 23;
	localparam int CLAT_W = LATP_W + 1;
	localparam int LONP_W = 24;
	localparam int CLON_W = LONP_W + 2;
	localparam int CALT_W = 21;

	localparam int LON_OFFSET = 360 * 1024;

	localparam int DEF_MAX_SECTORS   = 1024;
	localparam int DEF_GRID_ROWS     = 64;
	localparam int DEF_GRID_COLUMNS  = 128;
	localparam int DEF_GRID_LAYERS   = 16;
	localparam int DEF_CELL_CAPACITY = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [STEP_W-1:0] LAT_STEP_RESET = 16'd1024;
	localparam logic [STEP_W-1:0] LON_STEP_RESET = 16'd1024;
	localparam logic [STEP_W-1:0] ALT_STEP_RESET = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LON_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_STEP = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_VERTEX = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_READ,
		B_SEND
	} back_state_t;

	typedef struct packed {
		logic signed [CLAT_W-1:0] lat_lo;
		logic signed [CLAT_W-1:0] lat_hi;
		logic signed [CLON_W-1:0] lon_lo;
		logic signed [CLON_W-1:0] lon_hi;
		logic [CALT_W-1:0]        alt_lo;
		logic [CALT_W-1:0]        alt_hi;
	} cell_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [LAT_W-1:0] vlat;
		logic signed [LON_W-1:0] vlon;
		logic [ALT_W-1:0]        band_lo;
		logic [ALT_W-1:0]        band_hi;
		logic                    in_grid;
		cell_t                   bounds;
	} op_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] south;
		logic signed [LAT_W-1:0] north;
		logic signed [LON_W-1:0] west;
		logic signed [LON_W-1:0] east;
		logic [ALT_W-1:0]        alt_floor;
		logic [ALT_W-1:0]        alt_ceiling;
	} box_t;

	typedef struct packed {
		status_t          status;
		logic             hit;
		logic [NUM_W-1:0] num;
		logic             last;
		logic             ovf;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hw/rtl/sector_grid_box_query.sv @@
// Sector bounding-box binning against a uniform lat/lon/alt grid. Add-vertex,
// close and clear items give one result each. A query scans the box memory one
// stored sector per cycle, then returns the overlapping sectors it recorded,
// each through a hit buffer read and then the output register. The front computes
// the cell bounds and a two-entry queue lets it take further items while the back
// scans. The box memory needs no clearing pass after reset.
module sector_grid_box_query
	import sgbq_pkg::*;
#(
	parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
	parameter int GRID_ROWS     = DEF_GRID_ROWS,
	parameter int GRID_COLUMNS  = DEF_GRID_COLUMNS,
	parameter int GRID_LAYERS   = DEF_GRID_LAYERS,
	parameter int CELL_CAPACITY = DEF_CELL_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic signed [LAT_W-1:0] vertex_lat,
	input  logic signed [LON_W-1:0] vertex_lon,
	input  logic [ALT_W-1:0]        band_floor,
	input  logic [ALT_W-1:0]        band_ceiling,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [COL_W-1:0]        column_index,
	input  logic [LAYER_W-1:0]      layer_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic                    hit,
	output logic [NUM_W-1:0]        sector_number,
	output logic                    last,
	output logic                    overflow,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [STEP_W-1:0]       cfg_data
);

	logic    q_push;
	logic    q_pop;
	op_t     q_wr_op;
	op_t     q_rd_op;
	q_stat_t q_stat;

	sgbq_front #(
		.GRID_ROWS    (GRID_ROWS),
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_LAYERS  (GRID_LAYERS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.vertex_lat   (vertex_lat),
		.vertex_lon   (vertex_lon),
		.band_floor   (band_floor),
		.band_ceiling (band_ceiling),
		.row_index    (row_index),
		.column_index (column_index),
		.layer_index  (layer_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_push       (q_push),
		.q_op         (q_wr_op),
		.q_stat       (q_stat)
	);

	sgbq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_op  (q_wr_op),
		.pop    (q_pop),
		.rd_op  (q_rd_op),
		.stat   (q_stat)
	);

	sgbq_back #(
		.MAX_SECTORS   (MAX_SECTORS),
		.CELL_CAPACITY (CELL_CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_op          (q_rd_op),
		.q_stat        (q_stat),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.hit           (hit),
		.sector_number (sector_number),
		.last          (last),
		.overflow      (overflow)
	);

endmodule

@@ hw/rtl/sgbq_queue.sv @@
module sgbq_queue
	import sgbq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  op_t     wr_op,
	input  logic    pop,
	output op_t     rd_op,
	output q_stat_t stat
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_op      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

@@ hw/rtl/sgbq_front.sv @@
module sgbq_front
	import sgbq_pkg::*;
#(
	parameter int GRID_ROWS    = DEF_GRID_ROWS,
	parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
	parameter int GRID_LAYERS  = DEF_GRID_LAYERS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic signed [LAT_W-1:0] vertex_lat,
	input  logic signed [LON_W-1:0] vertex_lon,
	input  logic [ALT_W-1:0]        band_floor,
	input  logic [ALT_W-1:0]        band_ceiling,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [COL_W-1:0]        column_index,
	input  logic [LAYER_W-1:0]      layer_index,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [STEP_W-1:0]       cfg_data,
	output logic                    q_push,
	output op_t                     q_op,
	input  q_stat_t                 q_stat
);

	logic [STEP_W-1:0] lat_step_q;
	logic [STEP_W-1:0] lon_step_q;
	logic [STEP_W-1:0] alt_step_q;
	logic              valid_s1;
	op_t               op_s1;
	op_t               op_d;
	logic              accept;
	logic [LATP_W-1:0] lat_p0;
	logic [LATP_W-1:0] lat_p1;
	logic [LONP_W-1:0] lon_p0;
	logic [LONP_W-1:0] lon_p1;
	logic signed [CLON_W-1:0] lon_off;

	assign cfg_ready = 1'b1;
	assign q_push    = valid_s1;
	assign q_op      = op_s1;
	assign in_stall  = valid_s1 && q_stat.full;
	assign accept    = in_valid && !in_stall;
	assign lon_off   = $signed(CLON_W'(LON_OFFSET));

	always_comb begin
		lat_p0 = LATP_W'(row_index) * LATP_W'(lat_step_q);
		lat_p1 = (LATP_W'(row_index) + LATP_W'(1)) * LATP_W'(lat_step_q);
		lon_p0 = LONP_W'(column_index) * LONP_W'(lon_step_q);
		lon_p1 = (LONP_W'(column_index) + LONP_W'(1)) * LONP_W'(lon_step_q);

		op_d.cmd           = cmd_t'(command);
		op_d.vlat          = vertex_lat;
		op_d.vlon          = vertex_lon;
		op_d.band_lo       = band_floor;
		op_d.band_hi       = band_ceiling;
		op_d.in_grid       = (int'(row_index) < GRID_ROWS) &&
			(int'(column_index) < GRID_COLUMNS) && (int'(layer_index) < GRID_LAYERS);
		op_d.bounds.lat_lo = $signed({1'b0, lat_p0});
		op_d.bounds.lat_hi = $signed({1'b0, lat_p1});
		op_d.bounds.lon_lo = $signed({2'b00, lon_p0}) - lon_off;
		op_d.bounds.lon_hi = $signed({2'b00, lon_p1}) - lon_off;
		op_d.bounds.alt_lo = CALT_W'(layer_index) * CALT_W'(alt_step_q);
		op_d.bounds.alt_hi = (CALT_W'(layer_index) + CALT_W'(1)) * CALT_W'(alt_step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_step_q <= LAT_STEP_RESET;
			lon_step_q <= LON_STEP_RESET;
			alt_step_q <= ALT_STEP_RESET;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LAT_STEP: lat_step_q <= cfg_data;
					REG_LON_STEP: lon_step_q <= cfg_data;
					REG_ALT_STEP: alt_step_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (!q_stat.full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

endmodule

@@ hw/rtl/sgbq_back.sv @@
module sgbq_back
	import sgbq_pkg::*;
#(
	parameter int MAX_SECTORS   = DEF_MAX_SECTORS,
	parameter int CELL_CAPACITY = DEF_CELL_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              q_op,
	input  q_stat_t          q_stat,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [STATUS_W-1:0] status,
	output logic             hit,
	output logic [NUM_W-1:0] sector_number,
	output logic             last,
	output logic             overflow
);

	localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
	localparam int SW = $clog2(MAX_SECTORS + 1);
	localparam int HW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
	localparam int NW = $clog2(CELL_CAPACITY + 1);

	box_t        box_mem [MAX_SECTORS];
	logic [AW-1:0] hb_mem [CELL_CAPACITY];

	back_state_t st_q;
	back_state_t st_d;
	logic [SW-1:0] stored_q;
	logic          seen_q;
	logic signed [LAT_W-1:0] lat_min_q;
	logic signed [LAT_W-1:0] lat_max_q;
	logic signed [LON_W-1:0] lon_min_q;
	logic signed [LON_W-1:0] lon_max_q;
	cell_t         cell_q;
	logic [SW-1:0] scan_addr_q;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;
	box_t          rd_box_s1;
	logic [NW-1:0] n_q;
	logic [NW-1:0] k_q;
	logic          ovf_q;
	logic [AW-1:0] hb_rd_q;
	logic          out_valid_q;
	res_t          res_q;

	logic out_free;
	logic out_load;
	res_t res_d;
	logic do_vertex;
	logic box_we;
	logic close_done;
	logic do_clear;
	logic scan_start;
	logic rd_en;
	logic hb_rd_en;
	logic k_inc;
	logic match;
	logic send_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign send_last = ((k_q + NW'(1)) == n_q);

	assign match = rd_valid_s1 &&
		(cell_q.lat_hi >= CLAT_W'(rd_box_s1.south)) &&
		(cell_q.lat_lo <= CLAT_W'(rd_box_s1.north)) &&
		(cell_q.lon_hi >= CLON_W'(rd_box_s1.west)) &&
		(cell_q.lon_lo <= CLON_W'(rd_box_s1.east)) &&
		(cell_q.alt_hi >= CALT_W'(rd_box_s1.alt_floor)) &&
		(cell_q.alt_lo <= CALT_W'(rd_box_s1.alt_ceiling));

	always_comb begin
		st_d       = st_q;
		q_pop      = 1'b0;
		out_load   = 1'b0;
		res_d      = '{status: ST_OK, hit: 1'b0, num: '0, last: 1'b1, ovf: 1'b0};
		do_vertex  = 1'b0;
		box_we     = 1'b0;
		close_done = 1'b0;
		do_clear   = 1'b0;
		scan_start = 1'b0;
		rd_en      = 1'b0;
		hb_rd_en   = 1'b0;
		k_inc      = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (!q_stat.empty && out_free) begin
					q_pop = 1'b1;
					case (q_op.cmd)
						CMD_VERTEX: begin
							do_vertex = 1'b1;
							out_load  = 1'b1;
						end
						CMD_CLOSE: begin
							close_done = 1'b1;
							out_load   = 1'b1;
							if (!seen_q) begin
								res_d.status = ST_EMPTY;
							end else if (stored_q >= SW'(MAX_SECTORS)) begin
								res_d.status = ST_FULL;
							end else begin
								box_we = 1'b1;
							end
						end
						CMD_CLEAR: begin
							do_clear = 1'b1;
							out_load = 1'b1;
						end
						CMD_QUERY: begin
							if (q_op.in_grid) begin
								scan_start = 1'b1;
								st_d       = B_SCAN;
							end else begin
								out_load = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			B_SCAN: begin
				rd_en = (scan_addr_q < stored_q);
				if (!rd_en && !rd_valid_s1) begin
					st_d = B_READ;
				end
			end
			B_READ: begin
				if (n_q == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						st_d     = B_IDLE;
					end
				end else begin
					hb_rd_en = 1'b1;
					st_d     = B_SEND;
				end
			end
			B_SEND: begin
				if (out_free) begin
					out_load  = 1'b1;
					res_d.hit = 1'b1;
					res_d.num = NUM_W'(hb_rd_q);
					res_d.last = send_last;
					res_d.ovf = ovf_q;
					k_inc     = 1'b1;
					st_d      = send_last ? B_IDLE : B_READ;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			stored_q    <= '0;
			seen_q      <= 1'b0;
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			rd_valid_s1 <= rd_en;
			if (do_vertex) begin
				seen_q <= 1'b1;
			end
			if (close_done || do_clear) begin
				seen_q <= 1'b0;
			end
			if (box_we) begin
				stored_q <= stored_q + 1'b1;
			end
			if (do_clear) begin
				stored_q <= '0;
			end
			if (scan_start) begin
				scan_addr_q <= '0;
				n_q         <= '0;
				k_q         <= '0;
				ovf_q       <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_addr_q <= scan_addr_q + 1'b1;
				end
				if (match) begin
					if (n_q < NW'(CELL_CAPACITY)) begin
						n_q <= n_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (k_inc) begin
					k_q <= k_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_vertex) begin
			if (!seen_q) begin
				lat_min_q <= q_op.vlat;
				lat_max_q <= q_op.vlat;
				lon_min_q <= q_op.vlon;
				lon_max_q <= q_op.vlon;
			end else begin
				if (q_op.vlat < lat_min_q) lat_min_q <= q_op.vlat;
				if (q_op.vlat > lat_max_q) lat_max_q <= q_op.vlat;
				if (q_op.vlon < lon_min_q) lon_min_q <= q_op.vlon;
				if (q_op.vlon > lon_max_q) lon_max_q <= q_op.vlon;
			end
		end
		if (scan_start) begin
			cell_q <= q_op.bounds;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[stored_q[AW-1:0]] <= '{south: lat_min_q, north: lat_max_q,
				west: lon_min_q, east: lon_max_q,
				alt_floor: q_op.band_lo, alt_ceiling: q_op.band_hi};
		end
		if (rd_en) begin
			rd_box_s1 <= box_mem[scan_addr_q[AW-1:0]];
			rd_idx_s1 <= scan_addr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (match && (n_q < NW'(CELL_CAPACITY))) begin
			hb_mem[n_q[HW-1:0]] <= rd_idx_s1;
		end
		if (hb_rd_en) begin
			hb_rd_q <= hb_mem[k_q[HW-1:0]];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign hit           = res_q.hit;
	assign sector_number = res_q.num;
	assign last          = res_q.last;
	assign overflow      = res_q.ovf;

endmodule

@@ hw/rtl/sgbq_checker.sv @@
module sgbq_checker
	import sgbq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                hit,
	input logic [NUM_W-1:0]    sector_number,
	input logic                last,
	input logic                overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit) &&
			$stable(sector_number) && $stable(last) && $stable(overflow))
		else $error("stalled transfer changed");

	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> last && (sector_number == '0) && !overflow)
		else $error("miss result not final or not clean");

	a_error_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> !hit && last)
		else $error("error status on a hit");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (status == ST_OK))
		else $error("hit with bad status");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && hit && !last ##1 out_valid && hit |->
			(overflow == $past(overflow)))
		else $error("overflow changed within one query");

endmodule

bind sector_grid_box_query sgbq_checker u_sgbq_checker (.*);

@@ dv/tb_top.sv @@
module tb_top;
	import sgbq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  TABLE_DEPTH = DEF_MAX_SECTORS;
	localparam int  CAPACITY    = DEF_CELL_CAPACITY;
	localparam int  HOLD_CYCLES = 300;
	localparam int  CYCLE_LIMIT = 3_000_000;
	localparam int  LAT_MIN     = -131072;
	localparam int  LAT_MAX     = 131071;
	localparam int  LON_MIN     = -524288;
	localparam int  LON_MAX     = 524287;
	localparam int  ALT_MAX     = 131071;

	typedef struct {
		cmd_t                    cmd;
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		logic [ALT_W-1:0]        band_lo;
		logic [ALT_W-1:0]        band_hi;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic [LAYER_W-1:0]      layer;
		bit                      typed;
		status_t                 want;
	} sector_cmd_t;

	typedef struct {
		int r;
		int c;
		int l;
	} cell_pick_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [CMD_W-1:0]        command;
	logic signed [LAT_W-1:0] vertex_lat;
	logic signed [LON_W-1:0] vertex_lon;
	logic [ALT_W-1:0]        band_floor;
	logic [ALT_W-1:0]        band_ceiling;
	logic [ROW_W-1:0]        row_index;
	logic [COL_W-1:0]        column_index;
	logic [LAYER_W-1:0]      layer_index;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic                    hit;
	logic [NUM_W-1:0]        sector_number;
	logic                    last;
	logic                    overflow;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [STEP_W-1:0]       cfg_data;

	sector_grid_box_query dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.vertex_lat   (vertex_lat),
		.vertex_lon   (vertex_lon),
		.band_floor   (band_floor),
		.band_ceiling (band_ceiling),
		.row_index    (row_index),
		.column_index (column_index),
		.layer_index  (layer_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.sector_number(sector_number),
		.last         (last),
		.overflow     (overflow),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// grid step registers as the block should hold them
	longint lat_step = LAT_STEP_RESET;
	longint lon_step = LON_STEP_RESET;
	longint alt_step = ALT_STEP_RESET;

	logic signed [LAT_W-1:0] south_mem [TABLE_DEPTH];
	logic signed [LAT_W-1:0] north_mem [TABLE_DEPTH];
	logic signed [LON_W-1:0] west_mem [TABLE_DEPTH];
	logic signed [LON_W-1:0] east_mem [TABLE_DEPTH];
	logic [ALT_W-1:0]        floor_mem [TABLE_DEPTH];
	logic [ALT_W-1:0]        ceiling_mem [TABLE_DEPTH];
	int                      n_stored;
	longint                  open_lat_min, open_lat_max, open_lon_min, open_lon_max;
	bit                      open_seen;

	res_t       sector_replies [$];
	cell_pick_t targets [$];

	int errors;
	int items_sent;
	int queries_sent;
	int results_seen;
	int hits_seen;
	int overflows_seen;
	int step_settings;
	bit no_gaps;
	bit hold_req;

	sector_cmd_t directed_rows [24] = '{
		'{CMD_CLOSE,  0,       0,       0,      0,      0,  0,   0,  1, ST_EMPTY},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, -131072, -524288, 0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, 131071,  524287,  0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLOSE,  0,       0,       0,      131071, 0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, 0,       -368640, 0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, 1024,    -367616, 0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLOSE,  0,       0,       5000,   100,    0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, 512,     -368000, 0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLOSE,  0,       0,       0,      999,    0,  0,   0,  1, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  0,   0,  0, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      63, 127, 15, 0, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      1,  0,   0,  0, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  1,   0,  0, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  0,   5,  0, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  0,   1,  0, ST_OK},
		'{CMD_VERTEX, 5,       5,       0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLEAR,  0,       0,       0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLOSE,  0,       0,       0,      0,      0,  0,   0,  1, ST_EMPTY},
		'{CMD_VERTEX, -1,      -1,      0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_VERTEX, -2,      3,       0,      0,      0,  0,   0,  1, ST_OK},
		'{CMD_CLOSE,  0,       0,       131071, 131071, 0,  0,   0,  1, ST_OK},
		'{CMD_QUERY,  0,       0,       0,      0,      0,  127, 15, 0, ST_OK}
	};

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 85) return $urandom_range(1, 2);
		if (p < 97) return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	function automatic int span(longint reach, longint step, int top);
		if (step == 0 || reach / step >= top) return top;
		return int'(reach / step);
	endfunction

	function automatic int pin(int v, int top);
		if (v < 0) return 0;
		if (v > top) return top;
		return v;
	endfunction

	function automatic longint near(longint base, longint step, longint lo, longint hi);
		longint v;
		v = base - step / 4 + longint'($urandom_range(0, 32'(step + step / 2)));
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic sector_cmd_t rand_item();
		sector_cmd_t it;
		it.cmd     = cmd_t'($urandom_range(0, 3));
		it.lat     = LAT_W'($urandom());
		it.lon     = LON_W'($urandom());
		it.band_lo = ALT_W'($urandom());
		it.band_hi = ALT_W'($urandom());
		it.row     = ROW_W'($urandom());
		it.col     = COL_W'($urandom());
		it.layer   = LAYER_W'($urandom());
		it.typed   = 1'b0;
		it.want    = ST_OK;
		return it;
	endfunction

	task automatic apply_sector_command(input sector_cmd_t it);
		res_t   got [$];
		res_t   r;
		longint la0, la1, lo0, lo1, al0, al1;
		bit     ovf;
		r = '{status: ST_OK, hit: 1'b0, num: '0, last: 1'b1, ovf: 1'b0};
		ovf = 1'b0;
		case (it.cmd)
			CMD_VERTEX: begin
				if (!open_seen) begin
					open_lat_min = it.lat;
					open_lat_max = it.lat;
					open_lon_min = it.lon;
					open_lon_max = it.lon;
				end
				if (it.lat < open_lat_min) open_lat_min = it.lat;
				if (it.lat > open_lat_max) open_lat_max = it.lat;
				if (it.lon < open_lon_min) open_lon_min = it.lon;
				if (it.lon > open_lon_max) open_lon_max = it.lon;
				open_seen = 1'b1;
				got.push_back(r);
			end
			CMD_CLOSE: begin
				if (!open_seen) begin
					r.status = ST_EMPTY;
				end else if (n_stored >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					south_mem[n_stored]   = LAT_W'(open_lat_min);
					north_mem[n_stored]   = LAT_W'(open_lat_max);
					west_mem[n_stored]    = LON_W'(open_lon_min);
					east_mem[n_stored]    = LON_W'(open_lon_max);
					floor_mem[n_stored]   = it.band_lo;
					ceiling_mem[n_stored] = it.band_hi;
					n_stored++;
				end
				open_seen = 1'b0;
				got.push_back(r);
			end
			CMD_CLEAR: begin
				n_stored  = 0;
				open_seen = 1'b0;
				got.push_back(r);
			end
			default: begin
				if (it.row < DEF_GRID_ROWS && it.col < DEF_GRID_COLUMNS &&
						it.layer < DEF_GRID_LAYERS) begin
					la0 = longint'(it.row) * lat_step;
					la1 = (longint'(it.row) + 1) * lat_step;
					lo0 = longint'(it.col) * lon_step - LON_OFFSET;
					lo1 = (longint'(it.col) + 1) * lon_step - LON_OFFSET;
					al0 = longint'(it.layer) * alt_step;
					al1 = (longint'(it.layer) + 1) * alt_step;
					for (int s = 0; s < n_stored; s++) begin
						if (la1 >= longint'(south_mem[s]) && la0 <= longint'(north_mem[s]) &&
								lo1 >= longint'(west_mem[s]) && lo0 <= longint'(east_mem[s]) &&
								al1 >= longint'(floor_mem[s]) &&
								al0 <= longint'(ceiling_mem[s])) begin
							if (got.size() < CAPACITY) begin
								r.hit  = 1'b1;
								r.num  = s[NUM_W-1:0];
								r.last = 1'b0;
								got.push_back(r);
							end else begin
								ovf = 1'b1;
							end
						end
					end
				end
				if (got.size() == 0) begin
					got.push_back(r);
				end else begin
					foreach (got[k]) got[k].ovf = ovf;
					got[got.size() - 1].last = 1'b1;
				end
			end
		endcase
		if (it.typed)
			sector_replies.push_back('{status: it.want, hit: 1'b0, num: '0, last: 1'b1,
				ovf: 1'b0});
		else
			foreach (got[k]) sector_replies.push_back(got[k]);
	endtask

	task automatic send(input sector_cmd_t it);
		int gap;
		bit taken;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= it.cmd;
		vertex_lat   <= it.lat;
		vertex_lon   <= it.lon;
		band_floor   <= it.band_lo;
		band_ceiling <= it.band_hi;
		row_index    <= it.row;
		column_index <= it.col;
		layer_index  <= it.layer;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		apply_sector_command(it);
		items_sent++;
		if (it.cmd == CMD_QUERY) queries_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic set_steps(input logic [STEP_W-1:0] lat_v, input logic [STEP_W-1:0] lon_v,
			input logic [STEP_W-1:0] alt_v);
		write_reg(REG_LAT_STEP, lat_v);
		write_reg(REG_LON_STEP, lon_v);
		write_reg(REG_ALT_STEP, alt_v);
		cfg_valid <= 1'b0;
		lat_step = lat_v;
		lon_step = lon_v;
		alt_step = alt_v;
		step_settings++;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sector_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(input int quota);
		sector_cmd_t it;
		cell_pick_t  t;
		int          sent, p, nv;
		sent = 0;
		while (sent < quota) begin
			p  = $urandom_range(0, 99);
			it = rand_item();
			if (p < 45) begin
				t.r = $urandom_range(0, span(LAT_MAX, lat_step, DEF_GRID_ROWS - 1));
				t.c = $urandom_range(0, span(LON_MAX + LON_OFFSET, lon_step,
					DEF_GRID_COLUMNS - 1));
				t.l = $urandom_range(0, span(ALT_MAX, alt_step, DEF_GRID_LAYERS - 1));
				targets.push_back(t);
				if (targets.size() > 16) void'(targets.pop_front());
				nv = $urandom_range(1, 4);
				repeat (nv) begin
					it        = rand_item();
					it.cmd    = CMD_VERTEX;
					it.lat    = LAT_W'(near(t.r * lat_step, lat_step, LAT_MIN, LAT_MAX));
					it.lon    = LON_W'(near(t.c * lon_step - LON_OFFSET, lon_step, LON_MIN,
						LON_MAX));
					send(it);
					sent++;
				end
				// drop the close now and then so the next sector absorbs these vertices
				if ($urandom_range(0, 9) != 0) begin
					it         = rand_item();
					it.cmd     = CMD_CLOSE;
					it.band_lo = ALT_W'(near(t.l * alt_step, alt_step, 0, ALT_MAX));
					it.band_hi = ALT_W'(near((t.l + 1) * alt_step, alt_step, 0, ALT_MAX));
					send(it);
					sent++;
				end
			end else if (p < 80) begin
				it.cmd = CMD_QUERY;
				if (targets.size() > 0 && $urandom_range(0, 2) != 0) begin
					t        = targets[$urandom_range(0, targets.size() - 1)];
					it.row   = ROW_W'(pin(t.r + int'($urandom_range(0, 2)) - 1,
						DEF_GRID_ROWS - 1));
					it.col   = COL_W'(pin(t.c + int'($urandom_range(0, 2)) - 1,
						DEF_GRID_COLUMNS - 1));
					it.layer = LAYER_W'(pin(t.l + int'($urandom_range(0, 2)) - 1,
						DEF_GRID_LAYERS - 1));
				end
				send(it);
				sent++;
			end else begin
				if (p >= 97) it.cmd = CMD_CLEAR;
				send(it);
				sent++;
			end
		end
	endtask

	initial begin
		res_t              e;
		bit                grab;
		logic [STATUS_W-1:0] st_s;
		logic              hit_s, last_s, ovf_s;
		logic [NUM_W-1:0]  num_s;
		forever begin
			@(negedge clk);
			grab   = arst_n && out_valid && !out_stall;
			st_s   = status;
			hit_s  = hit;
			num_s  = sector_number;
			last_s = last;
			ovf_s  = overflow;
			@(posedge clk);
			if (grab) begin
				results_seen++;
				if (hit_s) hits_seen++;
				if (ovf_s) overflows_seen++;
				if (sector_replies.size() == 0) begin
					$error("result transfer with nothing outstanding");
					errors++;
				end else begin
					e = sector_replies.pop_front();
					if (st_s !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, st_s);
						errors++;
					end
					if (hit_s !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit_s);
						errors++;
					end
					if (num_s !== e.num) begin
						$error("sector_number: expected %0d, got %0d", e.num, num_s);
						errors++;
					end
					if (last_s !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last_s);
						errors++;
					end
					if (ovf_s !== e.ovf) begin
						$error("overflow: expected %0d, got %0d", e.ovf, ovf_s);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int run, len;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
				len = pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int cyc;
		for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		sector_cmd_t it;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_VERTEX;
		vertex_lat   = '0;
		vertex_lon   = '0;
		band_floor   = '0;
		band_ceiling = '0;
		row_index    = '0;
		column_index = '0;
		layer_index  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_LAT_STEP;
		cfg_data     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send(directed_rows[i]);
		wait_idle();

		// fill the table, starting with the result side held off
		hold_req = 1'b1;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			it         = rand_item();
			it.cmd     = CMD_VERTEX;
			it.lat     = LAT_W'($urandom_range(0, 2047));
			it.lon     = LON_W'(int'($urandom_range(0, 2047)) - LON_OFFSET);
			send(it);
			it         = rand_item();
			it.cmd     = CMD_CLOSE;
			it.band_lo = '0;
			it.band_hi = ALT_W'($urandom_range(0, 2500));
			send(it);
		end
		it       = rand_item();
		it.cmd   = CMD_VERTEX;
		it.typed = 1'b1;
		send(it);
		it.cmd   = CMD_CLOSE;
		it.want  = ST_FULL;
		send(it);
		it.want  = ST_EMPTY;
		send(it);
		repeat (6) begin
			it       = rand_item();
			it.cmd   = CMD_QUERY;
			it.row   = ROW_W'($urandom_range(0, 2));
			it.col   = COL_W'($urandom_range(0, 2));
			it.layer = LAYER_W'($urandom_range(0, 3));
			send(it);
		end
		it       = rand_item();
		it.cmd   = CMD_CLEAR;
		it.typed = 1'b1;
		it.want  = ST_OK;
		send(it);
		wait_idle();

		set_steps(16'd1, 16'd1, 16'd1);
		run_random(25);
		wait_idle();
		no_gaps = 1'b1;
		set_steps(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(25);
		no_gaps = 1'b0;
		wait_idle();
		set_steps(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 65535)));
		run_random(25);
		wait_idle();
		set_steps(16'd0, 16'd0, 16'd0);
		run_random(20);
		wait_idle();
		set_steps(16'($urandom_range(256, 4096)), 16'($urandom_range(256, 4096)),
			16'($urandom_range(256, 4096)));
		run_random(30);
		wait_idle();
		set_steps(LAT_STEP_RESET, LON_STEP_RESET, ALT_STEP_RESET);
		run_random(25);
		wait_idle();

		$display("Sent %0d items (%0d cell queries) under %0d step settings plus reset values.",
			items_sent, queries_sent, step_settings);
		$display("Checked %0d results: %0d sector hits, %0d flagged as over capacity.",
			results_seen, hits_seen, overflows_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
